@@ rtl/core/acpu_pkg.sv @@
package acpu_pkg;

    localparam int ADDR_BITS = 12;
    localparam int WORD_BITS = 16;
    localparam int CHAR_BITS = 8;

    typedef enum logic [2:0] {
        REQ_WRITE  = 3'd0,
        REQ_READ   = 3'd1,
        REQ_START  = 3'd2,
        REQ_STEP   = 3'd3,
        REQ_INPUT  = 3'd4,
        REQ_OUTACK = 3'd5
    } req_code_t;

    localparam logic [2:0] OP_AND = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_LDA = 3'd2;
    localparam logic [2:0] OP_STA = 3'd3;
    localparam logic [2:0] OP_BUN = 3'd4;
    localparam logic [2:0] OP_BSA = 3'd5;
    localparam logic [2:0] OP_ISZ = 3'd6;
    localparam logic [2:0] OP_REG = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_INDIRECT,
        ST_OPERAND,
        ST_EXEC,
        ST_ISZ_WB,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] data;
        logic [CHAR_BITS-1:0] in_char;
    } req_word_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic [ADDR_BITS-1:0] pc_now;
        logic [WORD_BITS-1:0] acc_now;
        logic                 extend_flag;
        logic                 is_running;
        logic [CHAR_BITS-1:0] out_char;
        logic                 out_strobe;
        logic                 int_enable;
        logic                 in_flag;
        logic                 out_flag;
    } rsp_word_t;

endpackage

@@ rtl/core/accumulator_cpu_instruction_step.sv @@
// Sequence from the accepting edge: write/start/input/ack and a halted step go
// straight to the result state, read passes through a read state, and a step
// runs fetch and decode, then for memory words indirect read (if I is set),
// operand read, execute (not STA/BUN/BSA), write back (ISZ only). Throughput:
// one word at a time; busy stays high through the result strobe, then drops in idle.
// Reset (rst_n, asynchronous, active low) clears all registers, sets the
// output flag; memory contents are undefined until written. Results cannot stall.
module accumulator_cpu_instruction_step
    import acpu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  req_word_t req,
    output logic      busy,
    output logic      done,
    output rsp_word_t rsp
);

    logic [WORD_BITS-1:0] mem [0:(1<<ADDR_BITS)-1];
    logic [WORD_BITS-1:0] mem_q;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_a;
    logic [WORD_BITS-1:0] mem_d;

    state_t state_reg, state_next;
    req_word_t req_reg, req_next;
    logic [ADDR_BITS-1:0] pc_reg, pc_next, ar_reg, ar_next;
    logic [WORD_BITS-1:0] ir_reg, ir_next, dr_reg, dr_next, ac_reg, ac_next;
    logic [WORD_BITS-1:0] rd_reg, rd_next;
    logic e_reg, e_next, s_reg, s_next, ien_reg, ien_next;
    logic fgi_reg, fgi_next, fgo_reg, fgo_next, strobe_reg, strobe_next;
    logic [CHAR_BITS-1:0] inpr_reg, inpr_next, outr_reg, outr_next;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS-1:0] ta;
    logic                 te;
    logic [ADDR_BITS-1:0] tp;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_a] <= mem_d;
        end
        mem_q <= mem[mem_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            ar_reg     <= '0;
            ir_reg     <= '0;
            dr_reg     <= '0;
            ac_reg     <= '0;
            e_reg      <= 1'b0;
            s_reg      <= 1'b0;
            ien_reg    <= 1'b0;
            fgi_reg    <= 1'b0;
            fgo_reg    <= 1'b1;
            inpr_reg   <= '0;
            outr_reg   <= '0;
            strobe_reg <= 1'b0;
            rd_reg     <= '0;
            req_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            ar_reg     <= ar_next;
            ir_reg     <= ir_next;
            dr_reg     <= dr_next;
            ac_reg     <= ac_next;
            e_reg      <= e_next;
            s_reg      <= s_next;
            ien_reg    <= ien_next;
            fgi_reg    <= fgi_next;
            fgo_reg    <= fgo_next;
            inpr_reg   <= inpr_next;
            outr_reg   <= outr_next;
            strobe_reg <= strobe_next;
            rd_reg     <= rd_next;
            req_reg    <= req_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        ar_next     = ar_reg;
        ir_next     = ir_reg;
        dr_next     = dr_reg;
        ac_next     = ac_reg;
        e_next      = e_reg;
        s_next      = s_reg;
        ien_next    = ien_reg;
        fgi_next    = fgi_reg;
        fgo_next    = fgo_reg;
        inpr_next   = inpr_reg;
        outr_next   = outr_reg;
        strobe_next = strobe_reg;
        rd_next     = rd_reg;
        req_next    = req_reg;
        mem_we      = 1'b0;
        mem_a       = ar_reg;
        mem_d       = ac_reg;
        sum         = '0;
        ta          = ac_reg;
        te          = e_reg;
        tp          = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_a = req.addr;
                mem_d = req.data;
                if (start)
                begin
                    req_next    = req;
                    strobe_next = 1'b0;
                    rd_next     = '0;
                    state_next  = ST_DONE;
                    unique case (req.req_type)
                        REQ_WRITE:  mem_we = 1'b1;
                        REQ_READ:   state_next = ST_READ;
                        REQ_START:
                        begin
                            pc_next = req.addr;
                            s_next  = 1'b1;
                        end
                        REQ_STEP:
                        begin
                            if (s_reg)
                            begin
                                ar_next    = pc_reg;
                                mem_a      = pc_reg;
                                state_next = ST_FETCH;
                            end
                        end
                        REQ_INPUT:
                        begin
                            inpr_next = req.in_char;
                            fgi_next  = 1'b1;
                        end
                        REQ_OUTACK: fgo_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                rd_next    = mem_q;
                state_next = ST_DONE;
            end
            ST_FETCH:
            begin
                ir_next    = mem_q;
                pc_next    = pc_reg + 1'b1;
                ar_next    = mem_q[ADDR_BITS-1:0];
                state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                state_next = ST_DONE;
                if (ir_reg[14:12] == OP_REG)
                begin
                    if (ir_reg[15])
                    begin
                        if (ir_reg[11])
                        begin
                            ta = {ta[15:8], inpr_reg};
                            fgi_next = 1'b0;
                        end
                        if (ir_reg[10])
                        begin
                            outr_next = ta[7:0];
                            fgo_next = 1'b0;
                            strobe_next = 1'b1;
                        end
                        if (ir_reg[9] && fgi_next) tp = tp + 1'b1;
                        if (ir_reg[8] && fgo_next) tp = tp + 1'b1;
                        if (ir_reg[7]) ien_next = 1'b1;
                        if (ir_reg[6]) ien_next = 1'b0;
                    end
                    else
                    begin
                        if (ir_reg[11]) ta = '0;
                        if (ir_reg[10]) te = 1'b0;
                        if (ir_reg[9]) ta = ~ta;
                        if (ir_reg[8]) te = ~te;
                        if (ir_reg[7])
                        begin
                            {ta, te} = {te, ta};
                        end
                        if (ir_reg[6])
                        begin
                            {te, ta} = {ta, te};
                        end
                        if (ir_reg[5]) ta = ta + 1'b1;
                        if (ir_reg[4] && !ta[15]) tp = tp + 1'b1;
                        if (ir_reg[3] && ta[15]) tp = tp + 1'b1;
                        if (ir_reg[2] && ta == '0) tp = tp + 1'b1;
                        if (ir_reg[1] && !te) tp = tp + 1'b1;
                        if (ir_reg[0]) s_next = 1'b0;
                    end
                    ac_next = ta;
                    e_next  = te;
                    pc_next = tp;
                end
                else if (ir_reg[15])
                begin
                    state_next = ST_INDIRECT;
                end
                else
                begin
                    state_next = ST_OPERAND;
                end
            end
            ST_INDIRECT:
            begin
                ar_next    = mem_q[ADDR_BITS-1:0];
                state_next = ST_OPERAND;
            end
            ST_OPERAND:
            begin
                state_next = ST_EXEC;
                unique case (ir_reg[14:12])
                    OP_STA:
                    begin
                        mem_we = 1'b1;
                        state_next = ST_DONE;
                    end
                    OP_BUN:
                    begin
                        pc_next = ar_reg;
                        state_next = ST_DONE;
                    end
                    OP_BSA:
                    begin
                        mem_we = 1'b1;
                        mem_d = {{(WORD_BITS-ADDR_BITS){1'b0}}, pc_reg};
                        ar_next = ar_reg + 1'b1;
                        pc_next = ar_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                    default: ;
                endcase
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                dr_next = mem_q;
                unique case (ir_reg[14:12])
                    OP_AND: ac_next = ac_reg & mem_q;
                    OP_ADD:
                    begin
                        sum = {1'b0, ac_reg} + {1'b0, mem_q};
                        ac_next = sum[WORD_BITS-1:0];
                        e_next = sum[WORD_BITS];
                    end
                    OP_LDA: ac_next = mem_q;
                    default:
                    begin
                        dr_next = mem_q + 1'b1;
                        state_next = ST_ISZ_WB;
                    end
                endcase
            end
            ST_ISZ_WB:
            begin
                mem_we = 1'b1;
                mem_d = dr_reg;
                if (dr_reg == '0) pc_next = pc_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_comb
    begin
        rsp.read_data   = rd_reg;
        rsp.pc_now      = pc_reg;
        rsp.acc_now     = ac_reg;
        rsp.extend_flag = e_reg;
        rsp.is_running  = s_reg;
        rsp.out_char    = outr_reg;
        rsp.out_strobe  = strobe_reg;
        rsp.int_enable  = ien_reg;
        rsp.in_flag     = fgi_reg;
        rsp.out_flag    = fgo_reg;
    end

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");
    a_no_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && req_reg.req_type != REQ_READ) |-> rsp.read_data == '0)
        else $error("read data on non-read word");
    a_strobe_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.out_strobe) |-> !rsp.out_flag)
        else $error("output flag set after output");
    a_halt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == REQ_STEP && !s_reg) |=> done)
        else $error("halted step not immediate");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import acpu_pkg::*;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam logic [15:0] W_CLA = 16'h7800;
    localparam logic [15:0] W_INC = 16'h7020;
    localparam logic [15:0] W_HLT = 16'h7001;
    localparam logic [15:0] W_INP = 16'hF800;
    localparam logic [15:0] W_OUT = 16'hF400;

    class cpu_scoreboard;
        logic [WORD_BITS-1:0] mem [1<<ADDR_BITS];
        bit                   written [1<<ADDR_BITS];
        logic [ADDR_BITS-1:0] pc;
        logic [WORD_BITS-1:0] acc;
        logic                 e, run, ien, iflag, oflag;
        logic [CHAR_BITS-1:0] ichr, ochr;
        rsp_word_t            pending_rsp [$];
        int                   errors;
        logic [ADDR_BITS-1:0] last_written;

        function new();
            pc = '0; acc = '0; e = 1'b0; run = 1'b0; ien = 1'b0; iflag = 1'b0;
            oflag = 1'b1; ichr = '0; ochr = '0; errors = 0; last_written = '0;
        endfunction

        function void put(logic [ADDR_BITS-1:0] a, logic [WORD_BITS-1:0] v);
            mem[a] = v;
            written[a] = 1'b1;
            last_written = a;
        endfunction

        // first address the next instruction would read that holds no word yet
        function bit missing(output logic [ADDR_BITS-1:0] a);
            logic [WORD_BITS-1:0] ins;
            logic [2:0]           op;
            logic [ADDR_BITS-1:0] ea;
            a = pc;
            if (!run) return 1'b0;
            if (!written[pc]) return 1'b1;
            ins = mem[pc];
            op = ins[14:12];
            if (op == OP_REG) return 1'b0;
            ea = ins[ADDR_BITS-1:0];
            if (ins[15])
            begin
                a = ea;
                if (!written[ea]) return 1'b1;
                ea = mem[ea][ADDR_BITS-1:0];
            end
            a = ea;
            if (op inside {OP_AND, OP_ADD, OP_LDA, OP_ISZ} && !written[ea]) return 1'b1;
            return 1'b0;
        endfunction

        function logic run_instr();
            logic [WORD_BITS-1:0] ins, w;
            logic [ADDR_BITS-1:0] ea;
            logic [WORD_BITS:0]   sum;
            logic                 lo, strobe;
            strobe = 1'b0;
            ins = mem[pc];
            pc = pc + 1'b1;
            ea = ins[ADDR_BITS-1:0];
            if (ins[14:12] == OP_REG)
            begin
                w = ins;
                if (ins[15])
                begin
                    if (w[11])
                    begin
                        acc[7:0] = ichr;
                        iflag = 1'b0;
                    end
                    if (w[10])
                    begin
                        ochr = acc[7:0];
                        oflag = 1'b0;
                        strobe = 1'b1;
                    end
                    if (w[9] && iflag) pc = pc + 1'b1;
                    if (w[8] && oflag) pc = pc + 1'b1;
                    if (w[7]) ien = 1'b1;
                    if (w[6]) ien = 1'b0;
                end
                else
                begin
                    if (w[11]) acc = '0;
                    if (w[10]) e = 1'b0;
                    if (w[9]) acc = ~acc;
                    if (w[8]) e = ~e;
                    if (w[7])
                    begin
                        lo = acc[0];
                        acc = {e, acc[15:1]};
                        e = lo;
                    end
                    if (w[6])
                    begin
                        lo = acc[15];
                        acc = {acc[14:0], e};
                        e = lo;
                    end
                    if (w[5]) acc = acc + 1'b1;
                    if (w[4] && !acc[15]) pc = pc + 1'b1;
                    if (w[3] && acc[15]) pc = pc + 1'b1;
                    if (w[2] && acc == '0) pc = pc + 1'b1;
                    if (w[1] && !e) pc = pc + 1'b1;
                    if (w[0]) run = 1'b0;
                end
                return strobe;
            end
            if (ins[15]) ea = mem[ea][ADDR_BITS-1:0];
            case (ins[14:12])
                OP_AND: acc = acc & mem[ea];
                OP_ADD:
                begin
                    sum = {1'b0, acc} + {1'b0, mem[ea]};
                    acc = sum[15:0];
                    e = sum[16];
                end
                OP_LDA: acc = mem[ea];
                OP_STA: put(ea, acc);
                OP_BUN: pc = ea;
                OP_BSA:
                begin
                    put(ea, {4'h0, pc});
                    pc = ea + 1'b1;
                end
                default:
                begin
                    w = mem[ea] + 1'b1;
                    put(ea, w);
                    if (w == '0) pc = pc + 1'b1;
                end
            endcase
            return 1'b0;
        endfunction

        function void note(req_word_t r);
            rsp_word_t x;
            x = '0;
            case (r.req_type)
                REQ_WRITE:  put(r.addr, r.data);
                REQ_READ:   x.read_data = mem[r.addr];
                REQ_START:
                begin
                    pc = r.addr;
                    run = 1'b1;
                end
                REQ_STEP:   if (run) x.out_strobe = run_instr();
                REQ_INPUT:
                begin
                    ichr = r.in_char;
                    iflag = 1'b1;
                end
                REQ_OUTACK: oflag = 1'b1;
                default: ;
            endcase
            x.pc_now = pc; x.acc_now = acc; x.extend_flag = e; x.is_running = run;
            x.out_char = ochr; x.int_enable = ien; x.in_flag = iflag; x.out_flag = oflag;
            pending_rsp.push_back(x);
        endfunction

        task report(string f, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h at %0t", f, got, want, $realtime);
            errors++;
        endtask

        task check(rsp_word_t g);
            rsp_word_t x;
            if (pending_rsp.size() == 0)
            begin
                report("unexpected word", 32'(g.pc_now), 32'd0);
                return;
            end
            x = pending_rsp.pop_front();
            if (g.read_data !== x.read_data) report("read_data", g.read_data, x.read_data);
            if (g.pc_now !== x.pc_now) report("pc_now", g.pc_now, x.pc_now);
            if (g.acc_now !== x.acc_now) report("acc_now", g.acc_now, x.acc_now);
            if (g.extend_flag !== x.extend_flag)
                report("extend_flag", g.extend_flag, x.extend_flag);
            if (g.is_running !== x.is_running) report("is_running", g.is_running, x.is_running);
            if (g.out_char !== x.out_char) report("out_char", g.out_char, x.out_char);
            if (g.out_strobe !== x.out_strobe) report("out_strobe", g.out_strobe, x.out_strobe);
            if (g.int_enable !== x.int_enable) report("int_enable", g.int_enable, x.int_enable);
            if (g.in_flag !== x.in_flag) report("in_flag", g.in_flag, x.in_flag);
            if (g.out_flag !== x.out_flag) report("out_flag", g.out_flag, x.out_flag);
        endtask
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      start = 0;
    req_word_t req = '0;
    logic      busy, done;
    rsp_word_t rsp;

    cpu_scoreboard sb = new();

    accumulator_cpu_instruction_step uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done) sb.check(rsp);

    task send(logic [2:0] kind, logic [ADDR_BITS-1:0] a, logic [WORD_BITS-1:0] d,
              logic [CHAR_BITS-1:0] ch);
        req_word_t r;
        int        g, n;
        r.req_type = kind; r.addr = a; r.data = d; r.in_char = ch;
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        sb.note(r);
        g = $urandom_range(0, 9);
        n = (g < 6) ? 0 : (g < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task step_filled();
        logic [ADDR_BITS-1:0] a;
        while (sb.missing(a))
            send(REQ_WRITE, a, WORD_BITS'($urandom), CHAR_BITS'($urandom));
        send(REQ_STEP, ADDR_BITS'($urandom), WORD_BITS'($urandom), CHAR_BITS'($urandom));
    endtask

    task read_known();
        logic [ADDR_BITS-1:0] a;
        a = ADDR_BITS'($urandom);
        if (!sb.written[a]) a = sb.last_written;
        send(REQ_READ, a, WORD_BITS'($urandom), CHAR_BITS'($urandom));
    endtask

    initial
    begin
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(REQ_WRITE, 12'hFFF, W_CLA, 8'h00);
        send(REQ_WRITE, 12'h000, 16'h1005, 8'h00);
        send(REQ_WRITE, 12'h005, 16'hFFFF, 8'hFF);
        send(REQ_WRITE, 12'h001, W_INC, 8'h00);
        send(REQ_WRITE, 12'h002, W_OUT, 8'h00);
        send(REQ_WRITE, 12'h003, W_INP, 8'h00);
        send(REQ_WRITE, 12'h004, W_HLT, 8'h00);
        send(REQ_READ, 12'hFFF, 16'h0000, 8'h00);
        send(REQ_READ, 12'h005, 16'hFFFF, 8'hFF);
        send(REQ_STEP, 12'h000, 16'h0000, 8'h00);
        send(REQ_START, 12'hFFF, 16'h0000, 8'h00);
        send(REQ_STEP, 12'h000, 16'h0000, 8'h00);
        send(REQ_STEP, 12'h000, 16'h0000, 8'h00);
        send(REQ_STEP, 12'h000, 16'h0000, 8'h00);
        send(REQ_STEP, 12'h000, 16'h0000, 8'h00);
        send(REQ_OUTACK, 12'h000, 16'h0000, 8'h00);
        send(REQ_INPUT, 12'hFFF, 16'hFFFF, 8'hFF);
        send(REQ_STEP, 12'h000, 16'h0000, 8'h00);
        send(REQ_STEP, 12'h000, 16'h0000, 8'h00);
        send(REQ_STEP, 12'h000, 16'h0000, 8'h00);
        send(REQ_SPARE_A, 12'h000, 16'h0000, 8'h00);
        send(REQ_SPARE_B, 12'hFFF, 16'hFFFF, 8'hFF);

        for (k = 0; k < 1000; k++)
        begin
            int p;
            if (k == 500)
            begin
                start <= 1'b0;
                wait (sb.pending_rsp.size() == 0);
                @(posedge clk);
            end
            p = $urandom_range(0, 99);
            if (!sb.run && p < 60) p = 95;
            if (p < 60) step_filled();
            else if (p < 72)
                send(REQ_WRITE, ADDR_BITS'($urandom), WORD_BITS'($urandom),
                     CHAR_BITS'($urandom));
            else if (p < 80) read_known();
            else if (p < 88)
                send(REQ_INPUT, ADDR_BITS'($urandom), WORD_BITS'($urandom),
                     CHAR_BITS'($urandom));
            else if (p < 94)
                send(REQ_OUTACK, ADDR_BITS'($urandom), WORD_BITS'($urandom),
                     CHAR_BITS'($urandom));
            else if (p < 98)
                send(REQ_START, ADDR_BITS'($urandom), WORD_BITS'($urandom),
                     CHAR_BITS'($urandom));
            else
                send($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B,
                     ADDR_BITS'($urandom), WORD_BITS'($urandom), CHAR_BITS'($urandom));
        end
        start <= 1'b0;
        wait (sb.pending_rsp.size() == 0);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("** accumulator_cpu_instruction_step: PASSED **");
        else
            $display("** accumulator_cpu_instruction_step: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** accumulator_cpu_instruction_step: FAILED **");
        $finish;
    end

endmodule
